/* hw/rtl/ptrm_pkg.sv */
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared constants and types for the periodic task release manager.
// ----------------------------------------------------------------------------
package ptrm_pkg;

   // default sizing
   localparam int MAX_TASKS_DEF  = 8;
   localparam int TIME_WIDTH_DEF = 8;

   // fixed field widths
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 3;
   localparam int FIELD_W  = 8;
   localparam int MASK_W   = 8;
   localparam int TICK_W   = 32;
   localparam int PEND_W   = 8;
   localparam int STAT_W   = 16;
   localparam int ACTIVE_W = 4;

   // request codes
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DONE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ATTR = 2'd2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd6;
   localparam logic [PEND_W-1:0]   PEND_MAX   = 8'hFF;
   localparam logic [STAT_W-1:0]   STAT_MAX   = 16'hFFFF;

   // per-task counter word held in the counter RAM
   typedef struct packed {
      logic [PEND_W-1:0] pend;
      logic [STAT_W-1:0] acts;
      logic [STAT_W-1:0] miss;
   } cnt_word_type;

endpackage

/* hw/rtl/ptrm_ram.sv */
// ----------------------------------------------------------------------------
// ptrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ptrm_mod.sv */
// ----------------------------------------------------------------------------
// ptrm_mod
// Bit-serial restoring modulo: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module ptrm_mod #(
   parameter int DW = 32,
   parameter int VW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [VW-1:0] remainder
);

   localparam int CNTW = $clog2(DW + 1);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   shf_ff, shf_in;
   logic [VW-1:0]   div_ff, div_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [VW:0]     trial;
   logic [VW-1:0]   rem_step;

   always_comb begin
      trial = {rem_ff, shf_ff[DW-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_step = VW'(trial - {1'b0, div_ff});
      end else begin
         rem_step = trial[VW-1:0];
      end

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      shf_in  = shf_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNTW'(DW);
         shf_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         shf_in = {shf_ff[DW-2:0], 1'b0};
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shf_ff <= shf_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/periodic_task_release_manager.sv */
// ----------------------------------------------------------------------------
// periodic_task_release_manager
// Periodic task table with release, resume and deadline-miss tracking.
// ----------------------------------------------------------------------------
//
//   channel   | handshake              | beat contents
//   ----------+------------------------+----------------------------------------
//   request   | start / busy           | req_mode, req_task_index, req_new_*
//   response  | rsp_strobe (1 cycle)   | masks, tick, addressed task statistics
//   csr       | csr_wr_en              | csr_wr_data = active task count
//
// Sequence: done, attribute and unused-mode beats go straight to the readout
// states SEL_RD and SEL_OUT. A tick first reads each examined task (at most
// MAX_TASKS) and runs the serial modulo over 32 tick bits if its period is
// nonzero, then a second read pass for resume and deadlines, then the readout.
// Reset: synchronous; valid bits read unwritten table entries as zero.
// Stalls: one beat in flight; busy falls at the edge that raises the strobe.
// ----------------------------------------------------------------------------
module periodic_task_release_manager #(
   parameter int MAX_TASKS  = ptrm_pkg::MAX_TASKS_DEF,
   parameter int TIME_WIDTH = ptrm_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [ptrm_pkg::MODE_W-1:0]         req_mode,
   input  logic [ptrm_pkg::INDEX_W-1:0]        req_task_index,
   input  logic [ptrm_pkg::FIELD_W-1:0]        req_new_period,
   input  logic [ptrm_pkg::FIELD_W-1:0]        req_new_phase,
   input  logic [ptrm_pkg::FIELD_W-1:0]        req_new_deadline,
   input  logic [ptrm_pkg::FIELD_W-1:0]        req_new_predecessors,
   // response
   output logic                                rsp_strobe,
   output logic [ptrm_pkg::MASK_W-1:0]         rsp_resume_mask,
   output logic [ptrm_pkg::MASK_W-1:0]         rsp_miss_mask,
   output logic [ptrm_pkg::TICK_W-1:0]         rsp_tick_now,
   output logic [ptrm_pkg::PEND_W-1:0]         rsp_sel_pending,
   output logic [ptrm_pkg::STAT_W-1:0]         rsp_sel_activations,
   output logic [ptrm_pkg::STAT_W-1:0]         rsp_sel_misses,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [ptrm_pkg::ACTIVE_W-1:0]       csr_wr_data
);

   localparam int TW      = TIME_WIDTH;
   localparam int AW      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW      = $clog2(MAX_TASKS + 1);
   localparam int ATTR_W  = 3 * TW + ptrm_pkg::FIELD_W;
   localparam int CNT_W   = $bits(ptrm_pkg::cnt_word_type);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_P1_RD   = 8'b0000_0010,
      ST_P1_CHK  = 8'b0000_0100,
      ST_P1_DIV  = 8'b0000_1000,
      ST_P2_RD   = 8'b0001_0000,
      ST_P2_EXE  = 8'b0010_0000,
      ST_SEL_RD  = 8'b0100_0000,
      ST_SEL_OUT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [ptrm_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [ptrm_pkg::INDEX_W-1:0]  idx_ff, idx_in;
   logic                          idx_ok_ff, idx_ok_in;
   logic [ptrm_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic [ptrm_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [CW-1:0]                 t_ff, t_in;
   logic [CW-1:0]                 n_ff, n_in;
   logic [TW-1:0]                 rem_ff [MAX_TASKS];
   logic [TW-1:0]                 rem_in;
   logic                          rem_we;
   logic [MAX_TASKS-1:0]          pnz_ff, pnz_in;
   logic [MAX_TASKS-1:0]          attr_vld_ff, attr_vld_in;
   logic [MAX_TASKS-1:0]          cnt_vld_ff, cnt_vld_in;
   logic                          attr_rv_ff, attr_rv_in;
   logic                          cnt_rv_ff, cnt_rv_in;
   logic [ptrm_pkg::MASK_W-1:0]   resume_ff, resume_in;
   logic [ptrm_pkg::MASK_W-1:0]   miss_ff, miss_in;

   // response registers
   logic                          strobe_ff, strobe_in;
   logic [ptrm_pkg::MASK_W-1:0]   o_resume_ff, o_resume_in;
   logic [ptrm_pkg::MASK_W-1:0]   o_miss_ff, o_miss_in;
   logic [ptrm_pkg::TICK_W-1:0]   o_tick_ff, o_tick_in;
   logic [ptrm_pkg::PEND_W-1:0]   o_pend_ff, o_pend_in;
   logic [ptrm_pkg::STAT_W-1:0]   o_acts_ff, o_acts_in;
   logic [ptrm_pkg::STAT_W-1:0]   o_miss_cnt_ff, o_miss_cnt_in;

   // RAM ports
   logic                 attr_we, attr_re;
   logic [AW-1:0]        attr_waddr;
   logic [ATTR_W-1:0]    attr_wdata, attr_rdata, attr_q;
   logic                 cnt_we, cnt_re;
   logic [AW-1:0]        cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]     cnt_rdata;
   ptrm_pkg::cnt_word_type cnt_q, cnt_wdata;

   // modulo unit
   logic                 mod_start, mod_done;
   logic [TW-1:0]        mod_rem;

   // decoded entry fields
   logic [TW-1:0]                per, ph, dl;
   logic [ptrm_pkg::FIELD_W-1:0] preds;
   logic [MAX_TASKS-1:0]         pred_vec;
   logic [AW-1:0]                t_a, idx_a, req_a;
   logic                         accept, req_ok, last, blocked, dead_hit, dec;

   assign t_a    = t_ff[AW-1:0];
   assign idx_a  = AW'(idx_ff);
   assign req_a  = AW'(req_task_index);
   assign accept = start && (state_ff == ST_IDLE);
   assign req_ok = (int'(req_task_index) < MAX_TASKS);
   assign last   = ((t_ff + 1'b1) == n_ff);

   // zero until first written
   assign attr_q = attr_rv_ff ? attr_rdata : '0;
   assign cnt_q  = cnt_rv_ff ? ptrm_pkg::cnt_word_type'(cnt_rdata) : '0;

   assign per   = attr_q[TW-1:0];
   assign ph    = attr_q[2*TW-1:TW];
   assign dl    = attr_q[3*TW-1:2*TW];
   assign preds = attr_q[ATTR_W-1:3*TW];

   // predecessor bits past the table are dropped
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_pred
      if (i < ptrm_pkg::FIELD_W) begin : g_in
         assign pred_vec[i] = preds[i];
      end else begin : g_out
         assign pred_vec[i] = 1'b0;
      end
   end

   assign blocked  = |(pred_vec & pnz_ff);
   // deadline + phase compared without wrap
   assign dead_hit = ({1'b0, rem_ff[t_a]} == ({1'b0, dl} + {1'b0, ph}));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      tick_in      = tick_ff;
      active_in    = csr_wr_en ? csr_wr_data : active_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      rem_in       = mod_rem;
      rem_we       = 1'b0;
      pnz_in       = pnz_ff;
      attr_vld_in  = attr_vld_ff;
      cnt_vld_in   = cnt_vld_ff;
      attr_rv_in   = attr_rv_ff;
      cnt_rv_in    = cnt_rv_ff;
      resume_in    = resume_ff;
      miss_in      = miss_ff;
      strobe_in    = 1'b0;
      o_resume_in  = o_resume_ff;
      o_miss_in    = o_miss_ff;
      o_tick_in    = o_tick_ff;
      o_pend_in    = o_pend_ff;
      o_acts_in    = o_acts_ff;
      o_miss_cnt_in = o_miss_cnt_ff;
      attr_we      = 1'b0;
      attr_re      = 1'b0;
      attr_waddr   = req_a;
      attr_wdata   = {req_new_predecessors, TW'(req_new_deadline), TW'(req_new_phase),
                      TW'(req_new_period)};
      cnt_we       = 1'b0;
      cnt_re       = 1'b0;
      cnt_waddr    = t_a;
      cnt_raddr    = t_a;
      cnt_wdata    = cnt_q;
      mod_start    = 1'b0;
      dec          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               idx_in    = req_task_index;
               idx_ok_in = req_ok;
               resume_in = '0;
               miss_in   = '0;
               t_in      = '0;
               if (int'(active_ff) > MAX_TASKS) begin
                  n_in = CW'(MAX_TASKS);
               end else begin
                  n_in = CW'(active_ff);
               end
               state_in = ST_SEL_RD;
               if (req_mode == ptrm_pkg::MODE_TICK) begin
                  tick_in = tick_ff + 1'b1;
                  if (int'(active_ff) != 0) begin
                     state_in = ST_P1_RD;
                  end
               end
               if (req_mode == ptrm_pkg::MODE_ATTR && req_ok) begin
                  attr_we            = 1'b1;
                  attr_vld_in[req_a] = 1'b1;
               end
            end
         end
         // release pass
         ST_P1_RD: begin
            attr_re    = 1'b1;
            cnt_re     = 1'b1;
            attr_rv_in = attr_vld_ff[t_a];
            cnt_rv_in  = cnt_vld_ff[t_a];
            state_in   = ST_P1_CHK;
         end
         ST_P1_CHK: begin
            if (per != '0) begin
               mod_start = 1'b1;
               state_in  = ST_P1_DIV;
            end else begin
               t_in     = last ? '0 : t_ff + 1'b1;
               state_in = last ? ST_P2_RD : ST_P1_RD;
            end
         end
         ST_P1_DIV: begin
            if (mod_done) begin
               rem_we = 1'b1;
               if (mod_rem == ph) begin
                  cnt_we         = 1'b1;
                  cnt_vld_in[t_a] = 1'b1;
                  pnz_in[t_a]    = 1'b1;
                  if (cnt_q.pend != ptrm_pkg::PEND_MAX) begin
                     cnt_wdata.pend = cnt_q.pend + 1'b1;
                  end
                  if (cnt_q.acts != ptrm_pkg::STAT_MAX) begin
                     cnt_wdata.acts = cnt_q.acts + 1'b1;
                  end
               end
               t_in     = last ? '0 : t_ff + 1'b1;
               state_in = last ? ST_P2_RD : ST_P1_RD;
            end
         end
         // resume and deadline pass
         ST_P2_RD: begin
            attr_re    = 1'b1;
            cnt_re     = 1'b1;
            attr_rv_in = attr_vld_ff[t_a];
            cnt_rv_in  = cnt_vld_ff[t_a];
            state_in   = ST_P2_EXE;
         end
         ST_P2_EXE: begin
            if (per != '0 && cnt_q.pend != '0) begin
               if (!blocked) begin
                  resume_in = resume_ff | (ptrm_pkg::MASK_W'(1) << t_ff);
               end
               if (dead_hit) begin
                  miss_in = miss_ff | (ptrm_pkg::MASK_W'(1) << t_ff);
                  cnt_we  = 1'b1;
                  cnt_vld_in[t_a] = 1'b1;
                  if (cnt_q.miss != ptrm_pkg::STAT_MAX) begin
                     cnt_wdata.miss = cnt_q.miss + 1'b1;
                  end
               end
            end
            t_in     = t_ff + 1'b1;
            state_in = last ? ST_SEL_RD : ST_P2_RD;
         end
         // readout of the addressed task
         ST_SEL_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = idx_a;
            cnt_rv_in = idx_ok_ff && cnt_vld_ff[idx_a];
            state_in  = ST_SEL_OUT;
         end
         ST_SEL_OUT: begin
            dec = (mode_ff == ptrm_pkg::MODE_DONE) && idx_ok_ff && (cnt_q.pend != '0);
            if (dec) begin
               cnt_we            = 1'b1;
               cnt_waddr         = idx_a;
               cnt_wdata.pend    = cnt_q.pend - 1'b1;
               cnt_vld_in[idx_a] = 1'b1;
               pnz_in[idx_a]     = (cnt_q.pend != ptrm_pkg::PEND_W'(1));
            end
            strobe_in     = 1'b1;
            o_resume_in   = resume_ff;
            o_miss_in     = miss_ff;
            o_tick_in     = tick_ff;
            o_pend_in     = idx_ok_ff ? cnt_wdata.pend : '0;
            o_acts_in     = idx_ok_ff ? cnt_q.acts : '0;
            o_miss_cnt_in = idx_ok_ff ? cnt_q.miss : '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tick_ff     <= '0;
         active_ff   <= ptrm_pkg::ACTIVE_RST;
         pnz_ff      <= '0;
         attr_vld_ff <= '0;
         cnt_vld_ff  <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         active_ff   <= active_in;
         pnz_ff      <= pnz_in;
         attr_vld_ff <= attr_vld_in;
         cnt_vld_ff  <= cnt_vld_in;
         strobe_ff   <= strobe_in;
      end
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      idx_ok_ff     <= idx_ok_in;
      t_ff          <= t_in;
      n_ff          <= n_in;
      attr_rv_ff    <= attr_rv_in;
      cnt_rv_ff     <= cnt_rv_in;
      resume_ff     <= resume_in;
      miss_ff       <= miss_in;
      o_resume_ff   <= o_resume_in;
      o_miss_ff     <= o_miss_in;
      o_tick_ff     <= o_tick_in;
      o_pend_ff     <= o_pend_in;
      o_acts_ff     <= o_acts_in;
      o_miss_cnt_ff <= o_miss_cnt_in;
      if (rem_we) begin
         rem_ff[t_a] <= rem_in;
      end
   end

   ptrm_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (MAX_TASKS)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (attr_waddr),
      .wr_data (attr_wdata),
      .rd_en   (attr_re),
      .rd_addr (t_a),
      .rd_data (attr_rdata)
   );

   ptrm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_TASKS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (CNT_W'(cnt_wdata)),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   ptrm_mod #(
      .DW (ptrm_pkg::TICK_W),
      .VW (TW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (tick_ff),
      .divisor   (per),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_resume_mask     = o_resume_ff;
   assign rsp_miss_mask       = o_miss_ff;
   assign rsp_tick_now        = o_tick_ff;
   assign rsp_sel_pending     = o_pend_ff;
   assign rsp_sel_activations = o_acts_ff;
   assign rsp_sel_misses      = o_miss_cnt_ff;

endmodule

/* hw/rtl/ptrm_checker.sv */
// ----------------------------------------------------------------------------
// ptrm_checker
// Port-level checks on the release manager's command and response beats.
// ----------------------------------------------------------------------------
module ptrm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // an accepted beat always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   // one response per beat, never back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held two cycles");

   // response lands as the block frees up
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   a_fell_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

endmodule

bind periodic_task_release_manager ptrm_checker u_ptrm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

/* bench/periodic_task_release_manager_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_release_manager_tb
// Self-checking bench for the periodic task release manager. Beats go in
// through the start/busy port. A behavioral copy of the task table predicts
// each status beat, and every strobed beat is checked field by field against
// the oldest prediction. Directed tests hit table extremes, predecessor
// chains, the deadline sum without wrap and active-count limits. A saturation
// run and a long random mix under several active-count settings follow.
// ----------------------------------------------------------------------------
module periodic_task_release_manager_tb;

   // mode 3 has no package name; the block must ignore it
   localparam logic [ptrm_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
   localparam int NUM_TASKS      = ptrm_pkg::MAX_TASKS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;   // idle cycles
   localparam int DRAIN_CYCLES   = 20;

   // one status beat as the block reports it
   typedef struct packed {
      logic [ptrm_pkg::MASK_W-1:0] resume;
      logic [ptrm_pkg::MASK_W-1:0] miss;
      logic [ptrm_pkg::TICK_W-1:0] tick;
      logic [ptrm_pkg::PEND_W-1:0] pend;
      logic [ptrm_pkg::STAT_W-1:0] acts;
      logic [ptrm_pkg::STAT_W-1:0] misses;
   } status_beat_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [ptrm_pkg::MODE_W-1:0]   req_mode;
   logic [ptrm_pkg::INDEX_W-1:0]  req_task_index;
   logic [ptrm_pkg::FIELD_W-1:0]  req_new_period;
   logic [ptrm_pkg::FIELD_W-1:0]  req_new_phase;
   logic [ptrm_pkg::FIELD_W-1:0]  req_new_deadline;
   logic [ptrm_pkg::FIELD_W-1:0]  req_new_predecessors;
   logic                          rsp_strobe;
   logic [ptrm_pkg::MASK_W-1:0]   rsp_resume_mask;
   logic [ptrm_pkg::MASK_W-1:0]   rsp_miss_mask;
   logic [ptrm_pkg::TICK_W-1:0]   rsp_tick_now;
   logic [ptrm_pkg::PEND_W-1:0]   rsp_sel_pending;
   logic [ptrm_pkg::STAT_W-1:0]   rsp_sel_activations;
   logic [ptrm_pkg::STAT_W-1:0]   rsp_sel_misses;
   logic                          csr_wr_en;
   logic [ptrm_pkg::ACTIVE_W-1:0] csr_wr_data;

   periodic_task_release_manager dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_task_index       (req_task_index),
      .req_new_period       (req_new_period),
      .req_new_phase        (req_new_phase),
      .req_new_deadline     (req_new_deadline),
      .req_new_predecessors (req_new_predecessors),
      .rsp_strobe           (rsp_strobe),
      .rsp_resume_mask      (rsp_resume_mask),
      .rsp_miss_mask        (rsp_miss_mask),
      .rsp_tick_now         (rsp_tick_now),
      .rsp_sel_pending      (rsp_sel_pending),
      .rsp_sel_activations  (rsp_sel_activations),
      .rsp_sel_misses       (rsp_sel_misses),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the task table, updated as each beat is accepted
   // ---------------------------------------------------------------------
   logic [ptrm_pkg::TICK_W-1:0]   sh_tick;
   logic [ptrm_pkg::FIELD_W-1:0]  sh_period   [NUM_TASKS];
   logic [ptrm_pkg::FIELD_W-1:0]  sh_phase    [NUM_TASKS];
   logic [ptrm_pkg::FIELD_W-1:0]  sh_deadline [NUM_TASKS];
   logic [ptrm_pkg::FIELD_W-1:0]  sh_preds    [NUM_TASKS];
   logic [ptrm_pkg::PEND_W-1:0]   sh_pend     [NUM_TASKS];
   logic [ptrm_pkg::STAT_W-1:0]   sh_acts     [NUM_TASKS];
   logic [ptrm_pkg::STAT_W-1:0]   sh_miss     [NUM_TASKS];
   logic [ptrm_pkg::ACTIVE_W-1:0] sh_active;

   status_beat_type awaited_status[$];

   int err_count;
   int n_tick, n_done, n_attr, n_none, n_csr;
   int resume_bits_seen, miss_bits_seen;
   int steady_beats;       // beats left in a no-gap stretch

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      err_count++;
   endtask

   // Advance the shadow table by one accepted beat and queue its status.
   task automatic predict_task_status(input logic [ptrm_pkg::MODE_W-1:0]  mode,
                                      input logic [ptrm_pkg::INDEX_W-1:0] idx,
                                      input logic [ptrm_pkg::FIELD_W-1:0] per,
                                      input logic [ptrm_pkg::FIELD_W-1:0] ph,
                                      input logic [ptrm_pkg::FIELD_W-1:0] dl,
                                      input logic [ptrm_pkg::FIELD_W-1:0] pr);
      status_beat_type st;
      int examined;
      logic blocked;
      logic [ptrm_pkg::TICK_W-1:0] rem;
      st = '0;
      case (mode)
         ptrm_pkg::MODE_TICK: begin
            examined = (sh_active > NUM_TASKS) ? NUM_TASKS : sh_active;
            sh_tick++;
            // release pass first, so resume sees this tick's releases
            for (int t = 0; t < examined; t++) begin
               if (sh_period[t] != '0 &&
                   (sh_tick % sh_period[t]) == ptrm_pkg::TICK_W'(sh_phase[t])) begin
                  if (sh_pend[t] != ptrm_pkg::PEND_MAX) sh_pend[t]++;
                  if (sh_acts[t] != ptrm_pkg::STAT_MAX) sh_acts[t]++;
               end
            end
            for (int t = 0; t < examined; t++) begin
               if (sh_period[t] == '0 || sh_pend[t] == '0) continue;
               blocked = 1'b0;
               // a predecessor can be any entry, even unexamined or itself
               for (int i = 0; i < NUM_TASKS; i++)
                  if (sh_preds[t][i] && sh_pend[i] != '0) blocked = 1'b1;
               if (!blocked) st.resume[t] = 1'b1;
               rem = sh_tick % sh_period[t];
               // deadline + phase is a full-width sum, no 8-bit wrap
               if (rem == ptrm_pkg::TICK_W'(sh_deadline[t]) +
                          ptrm_pkg::TICK_W'(sh_phase[t])) begin
                  if (sh_miss[t] != ptrm_pkg::STAT_MAX) sh_miss[t]++;
                  st.miss[t] = 1'b1;
               end
            end
         end
         ptrm_pkg::MODE_DONE: begin
            if (sh_pend[idx] != '0) sh_pend[idx]--;
         end
         ptrm_pkg::MODE_ATTR: begin
            sh_period[idx]   = per;
            sh_phase[idx]    = ph;
            sh_deadline[idx] = dl;
            sh_preds[idx]    = pr;
         end
         default: ;
      endcase
      st.tick   = sh_tick;
      st.pend   = sh_pend[idx];
      st.acts   = sh_acts[idx];
      st.misses = sh_miss[idx];
      awaited_status.push_back(st);
   endtask

   // Sender gap after a beat: mostly none or short, now and then long,
   // with stretches of back-to-back beats.
   task automatic sender_gap();
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (steady_beats > 0) begin
         steady_beats--;
         gap = 0;
      end else if (r < 3) begin
         steady_beats = $urandom_range(10, 40);
         gap = 0;
      end else if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drive one request beat and hold it until start && !busy at a rising edge.
   task automatic send_beat(input logic [ptrm_pkg::MODE_W-1:0]  mode,
                            input logic [ptrm_pkg::INDEX_W-1:0] idx,
                            input logic [ptrm_pkg::FIELD_W-1:0] per,
                            input logic [ptrm_pkg::FIELD_W-1:0] ph,
                            input logic [ptrm_pkg::FIELD_W-1:0] dl,
                            input logic [ptrm_pkg::FIELD_W-1:0] pr);
      @(negedge clock);
      start                = 1'b1;
      req_mode             = mode;
      req_task_index       = idx;
      req_new_period       = per;
      req_new_phase        = ph;
      req_new_deadline     = dl;
      req_new_predecessors = pr;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_task_status(mode, idx, per, ph, dl, pr);
      case (mode)
         ptrm_pkg::MODE_TICK: n_tick++;
         ptrm_pkg::MODE_DONE: n_done++;
         ptrm_pkg::MODE_ATTR: n_attr++;
         default:             n_none++;
      endcase
      sender_gap();
   endtask

   // Shorthands; ignored fields carry random noise
   task automatic send_tick();
      send_beat(ptrm_pkg::MODE_TICK, ptrm_pkg::INDEX_W'($urandom),
                ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom),
                ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom));
   endtask

   task automatic send_done(input logic [ptrm_pkg::INDEX_W-1:0] idx);
      send_beat(ptrm_pkg::MODE_DONE, idx,
                ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom),
                ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom));
   endtask

   // Lower start and wait until every status beat has come back.
   task automatic drain_requests();
      @(negedge clock);
      start = 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
   endtask

   // CSR write only while idle
   task automatic write_active_tasks(input logic [ptrm_pkg::ACTIVE_W-1:0] count);
      drain_requests();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = count;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      csr_wr_data = ptrm_pkg::ACTIVE_W'($urandom);
      sh_active   = count;
      n_csr++;
   endtask

   // ---------------------------------------------------------------------
   // Response checker: one strobe, one awaited beat
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      status_beat_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_status.size() == 0) begin
            flag_error("status beat with nothing awaited");
         end else begin
            want = awaited_status.pop_front();
            check_field("resume_mask", rsp_resume_mask, want.resume);
            check_field("miss_mask", rsp_miss_mask, want.miss);
            check_field("tick_now", rsp_tick_now, want.tick);
            check_field("sel_pending", rsp_sel_pending, want.pend);
            check_field("sel_activations", rsp_sel_activations, want.acts);
            check_field("sel_misses", rsp_sel_misses, want.misses);
            resume_bits_seen += $countones(want.resume);
            miss_bits_seen   += $countones(want.miss);
         end
      end
   end

   // Watchdog: too long with neither a request nor a status beat moving
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Fresh table: unused mode, done on an empty task, tick with nothing enabled
   task automatic test_reset_state();
      send_beat(MODE_NONE, 3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_done(3'd0);
      send_tick();
   endtask

   // Attribute extremes, chains and a task that waits on itself
   task automatic test_attr_extremes();
      // phase >= period: never releases
      send_beat(ptrm_pkg::MODE_ATTR, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // period 1, phase 0, deadline 0: release and miss every tick
      send_beat(ptrm_pkg::MODE_ATTR, 3'd0, 8'd1, 8'd0, 8'd0, 8'h00);
      // waits on task 0
      send_beat(ptrm_pkg::MODE_ATTR, 3'd1, 8'd2, 8'd1, 8'd0, 8'h01);
      // own predecessor: never resumes
      send_beat(ptrm_pkg::MODE_ATTR, 3'd2, 8'd3, 8'd0, 8'd1, 8'h04);
      // waits on an unexamined entry
      send_beat(ptrm_pkg::MODE_ATTR, 3'd5, 8'd4, 8'd2, 8'd1, 8'h80);
   endtask

   task automatic test_release_and_chain();
      repeat (4) send_tick();
      send_done(3'd0);
      send_done(3'd0);
      send_done(3'd1);
      send_tick();
      send_done(3'd2);
   endtask

   // Active count at zero, above the table size, and the deadline-sum edge
   task automatic test_active_limits();
      write_active_tasks(4'd0);
      send_tick();
      write_active_tasks(4'd15);
      // phase 1 + deadline 255 = 256 must not alias to remainder 0
      send_beat(ptrm_pkg::MODE_ATTR, 3'd7, 8'd2, 8'd1, 8'd255, 8'h00);
      send_tick();
      send_tick();
      send_tick();
      write_active_tasks(ptrm_pkg::ACTIVE_RST);
   endtask

   // Pending count pinned at its ceiling by a period-1 task with no retires
   task automatic test_pending_saturation();
      write_active_tasks(4'd1);
      send_beat(ptrm_pkg::MODE_ATTR, 3'd0, 8'd1, 8'd0, 8'd0, 8'h00);
      repeat (262) send_tick();
      send_done(3'd0);
      send_tick();
   endtask

   // Mostly well-formed traffic: small periods, phases inside the period,
   // deadlines that can be missed, sparse predecessor masks; some noise.
   task automatic test_random_mix(input int beats);
      int r;
      int first;
      logic [ptrm_pkg::INDEX_W-1:0] idx;
      logic [ptrm_pkg::FIELD_W-1:0] per, ph, dl, pr;
      for (int k = 0; k < beats; k++) begin
         r = $urandom_range(0, 99);
         if (r < 48) begin
            send_tick();
         end else if (r < 72) begin
            // prefer retiring a task that has something pending
            idx = ptrm_pkg::INDEX_W'($urandom);
            if ($urandom_range(0, 9) < 7) begin
               first = idx;
               for (int j = 0; j < NUM_TASKS; j++)
                  if (sh_pend[(first + j) % NUM_TASKS] != '0) begin
                     idx = ptrm_pkg::INDEX_W'((first + j) % NUM_TASKS);
                     break;
                  end
            end
            send_done(idx);
         end else if (r < 90) begin
            idx = ptrm_pkg::INDEX_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 5) per = 8'd0;
            else if (r < 80) per = ptrm_pkg::FIELD_W'($urandom_range(1, 12));
            else if (r < 95) per = ptrm_pkg::FIELD_W'($urandom_range(13, 40));
            else per = ptrm_pkg::FIELD_W'($urandom_range(41, 255));
            if (per != 0 && $urandom_range(0, 99) < 85) begin
               ph = ptrm_pkg::FIELD_W'($urandom_range(0, per - 1));
               dl = ptrm_pkg::FIELD_W'($urandom_range(0, per - 1));
            end else begin
               ph = ptrm_pkg::FIELD_W'($urandom);
               dl = ptrm_pkg::FIELD_W'($urandom);
            end
            r = $urandom_range(0, 9);
            if (r < 6) pr = 8'h00;
            else if (r < 9) pr = 8'h01 << $urandom_range(0, 7);
            else pr = ptrm_pkg::FIELD_W'($urandom);
            send_beat(ptrm_pkg::MODE_ATTR, idx, per, ph, dl, pr);
         end else if (r < 97) begin
            send_beat(ptrm_pkg::MODE_ATTR, ptrm_pkg::INDEX_W'($urandom),
                      ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom),
                      ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom));
         end else begin
            send_beat(MODE_NONE, ptrm_pkg::INDEX_W'($urandom),
                      ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom),
                      ptrm_pkg::FIELD_W'($urandom), ptrm_pkg::FIELD_W'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      start                = 1'b0;
      req_mode             = ptrm_pkg::MODE_TICK;
      req_task_index       = '0;
      req_new_period       = '0;
      req_new_phase        = '0;
      req_new_deadline     = '0;
      req_new_predecessors = '0;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      err_count        = 0;
      n_tick           = 0;
      n_done           = 0;
      n_attr           = 0;
      n_none           = 0;
      n_csr            = 0;
      resume_bits_seen = 0;
      miss_bits_seen   = 0;
      steady_beats     = 0;

      // shadow table reset
      sh_tick   = '0;
      sh_active = ptrm_pkg::ACTIVE_RST;
      for (int t = 0; t < NUM_TASKS; t++) begin
         sh_period[t]   = '0;
         sh_phase[t]    = '0;
         sh_deadline[t] = '0;
         sh_preds[t]    = '0;
         sh_pend[t]     = '0;
         sh_acts[t]     = '0;
         sh_miss[t]     = '0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_attr_extremes();
      test_release_and_chain();
      test_active_limits();
      test_pending_saturation();

      write_active_tasks(4'd8);
      test_random_mix(220);
      write_active_tasks(4'd3);
      test_random_mix(100);
      write_active_tasks(4'd15);
      test_random_mix(120);
      write_active_tasks(ptrm_pkg::ACTIVE_W'($urandom_range(1, 8)));
      test_random_mix(110);
      write_active_tasks(ptrm_pkg::ACTIVE_RST);
      test_random_mix(110);

      // let everything come back, then a short quiet tail
      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_status.size() != 0)
         flag_error($sformatf("%0d status beats never arrived", awaited_status.size()));

      $display("Run: %0d ticks, %0d done, %0d attribute and %0d unused-mode beats, %0d csr writes",
               n_tick, n_done, n_attr, n_none, n_csr);
      $display("Saw %0d resume bits and %0d deadline misses; final tick %0d",
               resume_bits_seen, miss_bits_seen, sh_tick);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ptrm_pkg.sv
hw/rtl/ptrm_ram.sv
hw/rtl/ptrm_mod.sv
hw/rtl/periodic_task_release_manager.sv
hw/rtl/ptrm_checker.sv
bench/periodic_task_release_manager_tb.sv
